FILE: design/i2cm_pkg.sv
// Shared types, constants and script tables of the I2C EEPROM byte master.
`timescale 1ns / 1ps

package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_READ      = 3'd2,
    OP_INVERT    = 3'd3,
    OP_BUS_RESET = 3'd4
  } op_t;

  // Bus primitives that make up a script.
  typedef enum logic [3:0] {
    PR_END   = 4'd0,
    PR_START = 4'd1,
    PR_B8    = 4'd2,
    PR_B9    = 4'd3,
    PR_ACK   = 4'd4,
    PR_READ  = 4'd5,
    PR_NACK  = 4'd6,
    PR_STOP  = 4'd7,
    PR_LOWQ  = 4'd8
  } prim_t;

  // Source of the shift register load at the start of a primitive.
  typedef enum logic [3:0] {
    SEL_NONE = 4'd0,
    SEL_CW   = 4'd1,
    SEL_CR   = 4'd2,
    SEL_AL   = 4'd3,
    SEL_DATA = 4'd4,
    SEL_ER   = 4'd5,
    SEL_EW   = 4'd6,
    SEL_INV  = 4'd7,
    SEL_ONES = 4'd8
  } sel_t;

  // How SDA is driven in a quarter-bit slot.
  typedef enum logic [1:0] {
    SDA_LOW  = 2'd0,
    SDA_REL  = 2'd1,
    SDA_KEEP = 2'd2,
    SDA_BIT  = 2'd3
  } sda_code_t;

  typedef struct packed {
    prim_t prim;
    sel_t  sel;
  } entry_t;

  typedef struct packed {
    logic      scl;
    sda_code_t code;
  } lv_t;

  // One result per tick.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] data;
  } res_t;

  localparam logic [7:0] CTRL_WRITE  = 8'hA0;
  localparam logic [7:0] CTRL_READ   = 8'hA1;
  localparam logic [7:0] EXP_WRITE   = 8'h70;
  localparam logic [7:0] EXP_READ    = 8'h71;
  localparam logic [8:0] NINE_ONES   = 9'h1FF;
  localparam logic [15:0] QBT_RESET  = 16'd4;

  function automatic entry_t script_entry(input op_t op, input logic [3:0] ph);
    entry_t e;
    e = '{prim: PR_END, sel: SEL_NONE};
    case (op)
      OP_WRITE: begin
        case (ph)
          4'd0: e = '{prim: PR_START, sel: SEL_NONE};
          4'd1: e = '{prim: PR_B8,    sel: SEL_CW};
          4'd2: e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd3: e = '{prim: PR_B8,    sel: SEL_AL};
          4'd4: e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd5: e = '{prim: PR_B8,    sel: SEL_DATA};
          4'd6: e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd7: e = '{prim: PR_STOP,  sel: SEL_NONE};
          default: e = '{prim: PR_END, sel: SEL_NONE};
        endcase
      end
      OP_READ: begin
        case (ph)
          4'd0:  e = '{prim: PR_START, sel: SEL_NONE};
          4'd1:  e = '{prim: PR_B8,    sel: SEL_CW};
          4'd2:  e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd3:  e = '{prim: PR_B8,    sel: SEL_AL};
          4'd4:  e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd5:  e = '{prim: PR_START, sel: SEL_NONE};
          4'd6:  e = '{prim: PR_B8,    sel: SEL_CR};
          4'd7:  e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd8:  e = '{prim: PR_READ,  sel: SEL_NONE};
          4'd9:  e = '{prim: PR_NACK,  sel: SEL_NONE};
          4'd10: e = '{prim: PR_STOP,  sel: SEL_NONE};
          default: e = '{prim: PR_END, sel: SEL_NONE};
        endcase
      end
      OP_INVERT: begin
        case (ph)
          4'd0:  e = '{prim: PR_START, sel: SEL_NONE};
          4'd1:  e = '{prim: PR_B8,    sel: SEL_ER};
          4'd2:  e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd3:  e = '{prim: PR_READ,  sel: SEL_NONE};
          4'd4:  e = '{prim: PR_NACK,  sel: SEL_NONE};
          4'd5:  e = '{prim: PR_STOP,  sel: SEL_NONE};
          4'd6:  e = '{prim: PR_START, sel: SEL_NONE};
          4'd7:  e = '{prim: PR_B8,    sel: SEL_EW};
          4'd8:  e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd9:  e = '{prim: PR_B8,    sel: SEL_INV};
          4'd10: e = '{prim: PR_ACK,   sel: SEL_NONE};
          4'd11: e = '{prim: PR_STOP,  sel: SEL_NONE};
          default: e = '{prim: PR_END, sel: SEL_NONE};
        endcase
      end
      OP_BUS_RESET: begin
        case (ph)
          4'd0: e = '{prim: PR_START, sel: SEL_NONE};
          4'd1: e = '{prim: PR_B9,    sel: SEL_ONES};
          4'd2: e = '{prim: PR_LOWQ,  sel: SEL_NONE};
          4'd3: e = '{prim: PR_START, sel: SEL_NONE};
          4'd4: e = '{prim: PR_STOP,  sel: SEL_NONE};
          default: e = '{prim: PR_END, sel: SEL_NONE};
        endcase
      end
      default: e = '{prim: PR_END, sel: SEL_NONE};
    endcase
    return e;
  endfunction

  function automatic logic [3:0] slot_total(input prim_t prim);
    logic [3:0] n;
    case (prim)
      PR_START:                   n = 4'd2;
      PR_B8, PR_B9:               n = 4'd6;
      PR_ACK:                     n = 4'd9;
      PR_READ, PR_NACK, PR_STOP:  n = 4'd4;
      default:                    n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic lv_t slot_levels(input prim_t prim, input logic [3:0] s);
    lv_t lv;
    lv = '{scl: 1'b0, code: SDA_KEEP};
    case (prim)
      PR_START: begin
        if (s == 4'd0) lv = '{scl: 1'b1, code: SDA_REL};
        else           lv = '{scl: 1'b1, code: SDA_LOW};
      end
      PR_B8, PR_B9: begin
        if (s == 4'd0)      lv = '{scl: 1'b0, code: SDA_KEEP};
        else if (s == 4'd1) lv = '{scl: 1'b0, code: SDA_BIT};
        else                lv = '{scl: 1'b1, code: SDA_BIT};
      end
      PR_ACK: begin
        if (s == 4'd5 || s == 4'd6) lv = '{scl: 1'b1, code: SDA_REL};
        else                        lv = '{scl: 1'b0, code: SDA_REL};
      end
      PR_READ: begin
        if (s == 4'd2) lv = '{scl: 1'b1, code: SDA_REL};
        else           lv = '{scl: 1'b0, code: SDA_REL};
      end
      PR_NACK: begin
        if (s == 4'd0)      lv = '{scl: 1'b0, code: SDA_KEEP};
        else if (s == 4'd1) lv = '{scl: 1'b0, code: SDA_REL};
        else                lv = '{scl: 1'b1, code: SDA_REL};
      end
      PR_STOP: begin
        if (s == 4'd0)      lv = '{scl: 1'b0, code: SDA_KEEP};
        else if (s == 4'd1) lv = '{scl: 1'b0, code: SDA_LOW};
        else if (s == 4'd2) lv = '{scl: 1'b1, code: SDA_LOW};
        else                lv = '{scl: 1'b1, code: SDA_REL};
      end
      default: lv = '{scl: 1'b0, code: SDA_KEEP};
    endcase
    return lv;
  endfunction

endpackage

FILE: design/i2c_eeprom_byte_master.sv
// Top level of the tick-stepped I2C EEPROM and expander byte master.
`timescale 1ns / 1ps

// Channel    Handshake             Payload
// request    in_valid / in_stall   operation, address, write_data, sda_in
// result     out_valid / out_stall scl_level, sda_level, busy_res, done_res, read_data
// config     cfg_write             cfg_data (quarter_bit_ticks)
//
// Every request is one bus time tick: the sequencer computes the new script
// position and the line levels from its state registers, and the result
// lands in an output register, so one request is accepted every clock cycle
// while in_stall is low. A two-entry result buffer lets a request be taken
// while an earlier result still waits; in_stall rises only when both entries
// are full. Synchronous reset returns the sequencer to idle with both lines
// released and quarter_bit_ticks set to four.
module i2c_eeprom_byte_master import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [10:0] address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data
);

  logic [15:0] quarter_bit_ticks;
  logic        accept;
  logic        buf_full;
  res_t        seq_res;
  res_t        out_res;

  // Only one register, so a write needs no address decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_bit_ticks <= QBT_RESET;
    end else if (cfg_write) begin
      quarter_bit_ticks <= cfg_data;
    end
  end

  // The request is taken whenever the skid register is free.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  i2cm_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .operation         (operation),
    .address           (address),
    .write_data        (write_data),
    .sda_in            (sda_in),
    .quarter_bit_ticks (quarter_bit_ticks),
    .res               (seq_res)
  );

  i2cm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (seq_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res),
    .full      (buf_full)
  );

  assign scl_level = out_res.scl;
  assign sda_level = out_res.sda;
  assign busy_res  = out_res.busy;
  assign done_res  = out_res.done;
  assign read_data = out_res.data;

endmodule

FILE: design/i2cm_seq.sv
// Bus sequencer: script state and the one-tick next-state and result logic.
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  operation,
  input  logic [10:0] address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  input  logic [15:0] quarter_bit_ticks,
  output res_t        res
);

  op_t         cur_op, cur_op_next;
  logic [3:0]  phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [3:0]  quarter_slot, quarter_slot_next;
  logic [15:0] tick_count, tick_count_next;
  logic [8:0]  shift_byte, shift_byte_next;
  logic [10:0] latched_address, latched_address_next;
  logic [7:0]  latched_data, latched_data_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        line_sda, line_sda_next;

  logic        start;
  op_t         op_e;
  logic [3:0]  phase_e;
  logic [15:0] q;
  entry_t      ent, ent_after;
  lv_t         lv;
  logic [3:0]  nbits;
  logic [3:0]  sh;
  logic        sda_out;
  logic        slot_end;
  logic        repeat_prim;
  logic [3:0]  qs_inc;
  logic [3:0]  bi_inc;
  logic [3:0]  phase_inc;

  function automatic logic [8:0] load_value(input sel_t sel, input logic [10:0] addr,
                                            input logic [7:0] data, input logic [7:0] rcv,
                                            input logic [8:0] cur);
    logic [7:0] page;
    logic [8:0] v;
    page = {4'b0000, addr[10:8], 1'b0};
    case (sel)
      SEL_CW:   v = {1'b0, CTRL_WRITE | page};
      SEL_CR:   v = {1'b0, CTRL_READ | page};
      SEL_AL:   v = {1'b0, addr[7:0]};
      SEL_DATA: v = {1'b0, data};
      SEL_ER:   v = {1'b0, EXP_READ};
      SEL_EW:   v = {1'b0, EXP_WRITE};
      SEL_INV:  v = {1'b0, ~rcv};
      SEL_ONES: v = NINE_ONES;
      default:  v = cur;
    endcase
    return v;
  endfunction

  always_comb begin
    q     = (quarter_bit_ticks == 16'd0) ? 16'd1 : quarter_bit_ticks;
    start = (cur_op == OP_TICK) &&
            (operation inside {OP_WRITE, OP_READ, OP_INVERT, OP_BUS_RESET});

    // A command on an idle tick takes effect on that same tick.
    op_e                 = start ? op_t'(operation) : cur_op;
    phase_e              = start ? 4'd0 : phase;
    latched_address_next = start ? address : latched_address;
    latched_data_next    = start ? write_data : latched_data;
    bit_index_next       = start ? 4'd0 : bit_index;
    quarter_slot_next    = start ? 4'd0 : quarter_slot;
    tick_count_next      = start ? 16'd0 : tick_count;
    shift_byte_next      = shift_byte;
    received_byte_next   = received_byte;
    cur_op_next          = op_e;
    phase_next           = phase_e;
    line_sda_next        = line_sda;

    ent         = script_entry(op_e, phase_e);
    lv          = slot_levels(ent.prim, quarter_slot_next);
    nbits       = (ent.prim == PR_B9) ? 4'd9 : 4'd8;
    sh          = (bit_index_next < nbits) ? (nbits - 4'd1 - bit_index_next) : 4'd0;
    repeat_prim = (ent.prim == PR_B8) || (ent.prim == PR_B9) || (ent.prim == PR_READ);
    qs_inc      = quarter_slot_next + 4'd1;
    bi_inc      = bit_index_next + 4'd1;
    phase_inc   = phase_e + 4'd1;
    ent_after   = script_entry(op_e, phase_inc);
    slot_end    = 1'b0;
    sda_out     = 1'b1;

    res = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0, data: 8'd0};

    if (op_e != OP_TICK) begin
      case (lv.code)
        SDA_KEEP: sda_out = line_sda;
        SDA_BIT:  sda_out = shift_byte_next[sh];
        SDA_LOW:  sda_out = 1'b0;
        default:  sda_out = 1'b1;
      endcase
      line_sda_next = sda_out;
      res.scl  = lv.scl;
      res.sda  = sda_out;
      res.busy = 1'b1;

      // Read bits are sampled on the first tick of the SCL-high slot.
      if (ent.prim == PR_READ && quarter_slot_next == 4'd2 && tick_count_next == 16'd0) begin
        shift_byte_next = {shift_byte_next[7:0], sda_in};
      end

      if (ent.prim == PR_ACK && quarter_slot_next == 4'd4) begin
        slot_end = !sda_in;
      end else if ({1'b0, tick_count_next} + 17'd1 >= {1'b0, q}) begin
        slot_end = 1'b1;
      end else begin
        tick_count_next = tick_count_next + 16'd1;
      end

      if (slot_end) begin
        tick_count_next   = 16'd0;
        quarter_slot_next = qs_inc;
        if (qs_inc >= slot_total(ent.prim)) begin
          quarter_slot_next = 4'd0;
          if (repeat_prim) begin
            bit_index_next = bi_inc;
          end
          if (!repeat_prim || bi_inc >= nbits) begin
            if (ent.prim == PR_READ) begin
              received_byte_next = shift_byte_next[7:0];
            end
            phase_next = phase_inc;
            if (ent_after.prim == PR_END) begin
              cur_op_next    = OP_TICK;
              phase_next     = 4'd0;
              bit_index_next = 4'd0;
              line_sda_next  = 1'b1;
              res.done       = 1'b1;
            end else begin
              bit_index_next  = 4'd0;
              shift_byte_next = load_value(ent_after.sel, latched_address_next,
                                           latched_data_next, received_byte_next,
                                           shift_byte_next);
            end
          end
        end
      end
    end else begin
      line_sda_next = 1'b1;
    end

    res.data = received_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op          <= OP_TICK;
      phase           <= 4'd0;
      bit_index       <= 4'd0;
      quarter_slot    <= 4'd0;
      tick_count      <= 16'd0;
      shift_byte      <= 9'd0;
      latched_address <= 11'd0;
      latched_data    <= 8'd0;
      received_byte   <= 8'd0;
      line_sda        <= 1'b1;
    end else if (accept) begin
      cur_op          <= cur_op_next;
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      quarter_slot    <= quarter_slot_next;
      tick_count      <= tick_count_next;
      shift_byte      <= shift_byte_next;
      latched_address <= latched_address_next;
      latched_data    <= latched_data_next;
      received_byte   <= received_byte_next;
      line_sda        <= line_sda_next;
    end
  end

  // Idle means the whole script position is back at its origin.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (cur_op == OP_TICK) |-> (phase == 4'd0 && bit_index == 4'd0 &&
                             tick_count == 16'd0 && quarter_slot == 4'd0))
    else $error("idle sequencer holds a stale script position");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    quarter_slot < 4'd9)
    else $error("quarter slot beyond the longest primitive");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (accept && res.done) |=> (cur_op == OP_TICK))
    else $error("operation finished but sequencer did not return to idle");

endmodule

FILE: design/i2cm_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module i2cm_out_buf import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  input  logic out_stall,
  output logic out_valid,
  output res_t out_data,
  output logic full
);

  logic pop;
  res_t skid_data;

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else begin
      if (pop) begin
        if (full) begin
          full      <= 1'b0;
          out_valid <= 1'b1;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
        end else begin
          full <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (full) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    full |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_stalled_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or was dropped");

  a_drained_goes_empty: assert property (@(posedge clk) disable iff (rst)
    (pop && !full && !push) |=> !out_valid)
    else $error("output register still valid after its last result left");

endmodule

FILE: bench/tb_i2c_eeprom_byte_master.sv
// Self-checking testbench of the tick-stepped I2C EEPROM and expander byte master.
`timescale 1ns / 1ps

// Each request is one bus time tick. For every accepted request the bench steps
// its own model of the bus sequencer and queues the result it predicts. The
// result channel is checked field by field in order. Directed rows come first:
// idle ticks, unused operation codes, every operation, a command while busy, a
// very late acknowledge and a zero quarter-bit setting. Random phases at drawn
// bus speeds follow while the tick budget lasts. The run closes at the widest
// quarter-bit setting.
module tb_i2c_eeprom_byte_master;
  import i2cm_pkg::*;

  // Operation codes that the block must treat as a plain tick.
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // What a directed row does once its request has been accepted.
  localparam int NO_DRAIN       = 0;
  localparam int DRAIN          = 1;
  localparam int DRAIN_LATE_ACK = 2;
  localparam int NO_CFG         = -1;

  // Results that can be read straight off the behaviour.
  localparam res_t IDLE_RES  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam res_t START_RES = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00};

  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] addr;
    logic [7:0]  data;
    logic        sda;
  } tick_req_t;

  typedef struct {
    tick_req_t req;
    int        set_q;
    int        drain;
    bit        known;
    res_t      want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [10:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        sda_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;

  i2c_eeprom_byte_master u_top (
    .clk, .rst, .cfg_write, .cfg_data, .in_valid, .in_stall, .operation,
    .address, .write_data, .sda_in, .out_valid, .out_stall, .scl_level,
    .sda_level, .busy_res, .done_res, .read_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results predicted for accepted requests, oldest first.
  res_t awaited_results[$];

  // The bench's own copy of the sequencer state and of the quarter-bit register.
  op_t         run_op = OP_TICK;
  logic [3:0]  run_pos = '0;
  logic [3:0]  bit_no = '0;
  logic [3:0]  slot_no = '0;
  logic [8:0]  shreg = '0;
  logic [15:0] tick_cnt = '0;
  logic [10:0] addr_hold = '0;
  logic [7:0]  data_hold = '0;
  logic [7:0]  rx_byte = '0;
  logic        sda_line = 1'b1;
  logic [15:0] qbt_model = QBT_RESET;

  int finished[8];
  int ticks_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int speeds_used = 0;
  int ack_hold_left = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  // Script of each operation as {primitive, shift load source}, one step per position.
  function automatic logic [7:0] script_step(input op_t op, input logic [3:0] pos);
    logic [7:0] s;
    s = {PR_END, SEL_NONE};
    case (op)
      OP_WRITE, OP_READ: begin
        case (pos)
          4'd0: s = {PR_START, SEL_NONE};
          4'd1: s = {PR_B8, SEL_CW};
          4'd2: s = {PR_ACK, SEL_NONE};
          4'd3: s = {PR_B8, SEL_AL};
          4'd4: s = {PR_ACK, SEL_NONE};
          default: begin
            if (op == OP_WRITE) begin
              case (pos)
                4'd5: s = {PR_B8, SEL_DATA};
                4'd6: s = {PR_ACK, SEL_NONE};
                4'd7: s = {PR_STOP, SEL_NONE};
                default: s = {PR_END, SEL_NONE};
              endcase
            end else begin
              case (pos)
                4'd5:  s = {PR_START, SEL_NONE};
                4'd6:  s = {PR_B8, SEL_CR};
                4'd7:  s = {PR_ACK, SEL_NONE};
                4'd8:  s = {PR_READ, SEL_NONE};
                4'd9:  s = {PR_NACK, SEL_NONE};
                4'd10: s = {PR_STOP, SEL_NONE};
                default: s = {PR_END, SEL_NONE};
              endcase
            end
          end
        endcase
      end
      OP_INVERT: begin
        case (pos)
          4'd0, 4'd6: s = {PR_START, SEL_NONE};
          4'd1:       s = {PR_B8, SEL_ER};
          4'd3:       s = {PR_READ, SEL_NONE};
          4'd4:       s = {PR_NACK, SEL_NONE};
          4'd5, 4'd11: s = {PR_STOP, SEL_NONE};
          4'd7:       s = {PR_B8, SEL_EW};
          4'd9:       s = {PR_B8, SEL_INV};
          4'd2, 4'd8, 4'd10: s = {PR_ACK, SEL_NONE};
          default:    s = {PR_END, SEL_NONE};
        endcase
      end
      OP_BUS_RESET: begin
        case (pos)
          4'd0, 4'd3: s = {PR_START, SEL_NONE};
          4'd1:       s = {PR_B9, SEL_ONES};
          4'd2:       s = {PR_LOWQ, SEL_NONE};
          4'd4:       s = {PR_STOP, SEL_NONE};
          default:    s = {PR_END, SEL_NONE};
        endcase
      end
      default: s = {PR_END, SEL_NONE};
    endcase
    return s;
  endfunction

  function automatic int slots_in(input prim_t p);
    case (p)
      PR_START:                  return 2;
      PR_B8, PR_B9:              return 6;
      PR_ACK:                    return 9;
      PR_READ, PR_NACK, PR_STOP: return 4;
      default:                   return 1;
    endcase
  endfunction

  // Clock level and data line source for one quarter-bit slot of a primitive.
  function automatic void slot_drive(input prim_t p, input logic [3:0] slot,
                                     output logic scl, output sda_code_t code);
    scl = 1'b0;
    code = SDA_KEEP;
    case (p)
      PR_START: begin
        scl = 1'b1;
        code = (slot == 4'd0) ? SDA_REL : SDA_LOW;
      end
      PR_B8, PR_B9: begin
        scl = (slot >= 4'd2);
        code = (slot == 4'd0) ? SDA_KEEP : SDA_BIT;
      end
      PR_ACK: begin
        scl = (slot == 4'd5 || slot == 4'd6);
        code = SDA_REL;
      end
      PR_READ: begin
        scl = (slot == 4'd2);
        code = SDA_REL;
      end
      PR_NACK: begin
        scl = (slot >= 4'd2);
        code = (slot == 4'd0) ? SDA_KEEP : SDA_REL;
      end
      PR_STOP: begin
        scl = (slot >= 4'd2);
        if (slot == 4'd0)      code = SDA_KEEP;
        else if (slot == 4'd3) code = SDA_REL;
        else                   code = SDA_LOW;
      end
      default: ;
    endcase
  endfunction

  // Enters the script step at run_pos and loads the byte it will shift out.
  function automatic void load_step();
    logic [7:0] st;
    logic [7:0] page;
    st = script_step(run_op, run_pos);
    page = {4'd0, addr_hold[10:8], 1'b0};
    bit_no = '0;
    slot_no = '0;
    tick_cnt = '0;
    case (sel_t'(st[3:0]))
      SEL_CW:   shreg = {1'b0, CTRL_WRITE | page};
      SEL_CR:   shreg = {1'b0, CTRL_READ | page};
      SEL_AL:   shreg = {1'b0, addr_hold[7:0]};
      SEL_DATA: shreg = {1'b0, data_hold};
      SEL_ER:   shreg = {1'b0, EXP_READ};
      SEL_EW:   shreg = {1'b0, EXP_WRITE};
      SEL_INV:  shreg = {1'b0, ~rx_byte};
      SEL_ONES: shreg = NINE_ONES;
      default:  ;
    endcase
  endfunction

  // Advances the sequencer copy by one bus tick and returns the line levels it drives.
  function automatic res_t advance_bus(input tick_req_t r);
    res_t       res;
    logic [7:0] st;
    prim_t      prim;
    int         nbits;
    int         q;
    logic       scl;
    sda_code_t  code;
    logic       sda_o;
    bit         slot_end;
    bit         again;
    res = '0;
    q = (qbt_model == 16'd0) ? 1 : int'(qbt_model);
    // A command is only taken while nothing is running; codes above the bus
    // reset are plain ticks.
    if (run_op == OP_TICK && r.op >= OP_WRITE && r.op <= OP_BUS_RESET) begin
      run_op = op_t'(r.op);
      run_pos = '0;
      addr_hold = r.addr;
      data_hold = r.data;
      load_step();
    end
    if (run_op != OP_TICK) begin
      st = script_step(run_op, run_pos);
      prim = prim_t'(st[7:4]);
      nbits = (prim == PR_B9) ? 9 : 8;
      slot_drive(prim, slot_no, scl, code);
      case (code)
        SDA_KEEP: sda_o = sda_line;
        SDA_BIT:  sda_o = (bit_no < nbits) ? shreg[nbits - 1 - bit_no] : shreg[0];
        SDA_LOW:  sda_o = 1'b0;
        default:  sda_o = 1'b1;
      endcase
      sda_line = sda_o;
      // A read bit is taken on the first tick with the clock high.
      if (prim == PR_READ && slot_no == 4'd2 && tick_cnt == 16'd0)
        shreg = {shreg[7:0], r.sda};
      // The acknowledge wait lasts until the slave pulls the data line low.
      if (prim == PR_ACK && slot_no == 4'd4) begin
        slot_end = !r.sda;
      end else if (int'(tick_cnt) + 1 >= q) begin
        slot_end = 1'b1;
      end else begin
        slot_end = 1'b0;
        tick_cnt = tick_cnt + 16'd1;
      end
      if (slot_end) begin
        tick_cnt = '0;
        slot_no = slot_no + 4'd1;
        if (slot_no >= slots_in(prim)) begin
          again = (prim == PR_B8 || prim == PR_B9 || prim == PR_READ);
          slot_no = '0;
          if (again) bit_no = bit_no + 4'd1;
          if (!again || bit_no >= nbits) begin
            if (prim == PR_READ) rx_byte = shreg[7:0];
            run_pos = run_pos + 4'd1;
            st = script_step(run_op, run_pos);
            if (prim_t'(st[7:4]) == PR_END) begin
              finished[run_op]++;
              run_op = OP_TICK;
              run_pos = '0;
              bit_no = '0;
              sda_line = 1'b1;
              res.done = 1'b1;
            end else begin
              load_step();
            end
          end
        end
      end
      res.scl = scl;
      res.sda = sda_o;
      res.busy = 1'b1;
    end else begin
      sda_line = 1'b1;
      res.scl = 1'b1;
      res.sda = 1'b1;
    end
    res.data = rx_byte;
    return res;
  endfunction

  function automatic bit awaiting_ack();
    logic [7:0] st;
    st = script_step(run_op, run_pos);
    return run_op != OP_TICK && prim_t'(st[7:4]) == PR_ACK && slot_no == 4'd4;
  endfunction

  // The slave mostly answers an acknowledge wait at once, but sometimes keeps the
  // line released for a while so that the master has to hold.
  function automatic logic pick_sda();
    if (!awaiting_ack()) return 1'($urandom());
    if (ack_hold_left != 0) begin
      ack_hold_left--;
      return 1'b1;
    end
    if ($urandom_range(0, 19) == 0) begin
      ack_hold_left = $urandom_range(10, 60);
      return 1'b1;
    end
    return ($urandom_range(0, 3) == 0);
  endfunction

  // While idle a command is usually started; while busy every code is sent and
  // must be ignored.
  function automatic tick_req_t random_request();
    tick_req_t r;
    if (run_op == OP_TICK && $urandom_range(0, 9) < 7)
      r.op = 3'($urandom_range(OP_WRITE, OP_BUS_RESET));
    else
      r.op = 3'($urandom());
    r.addr = 11'($urandom());
    r.data = 8'($urandom());
    r.sda = pick_sda();
    return r;
  endfunction

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic plan_row_t plan_row(input logic [2:0] op, input logic [10:0] a,
                                         input logic [7:0] d, input logic s,
                                         input int set_q, input int drain,
                                         input bit known, input res_t want);
    plan_row_t row;
    row.req = '{op, a, d, s};
    row.set_q = set_q;
    row.drain = drain;
    row.known = known;
    row.want = want;
    return row;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Presents one request after a drawn gap and returns at the edge that takes it.
  task automatic drive_request(input tick_req_t r);
    int gap;
    gap = idle_draw(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= r.op;
    address    <= r.addr;
    write_data <= r.data;
    sda_in     <= r.sda;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic send_tick(input tick_req_t r);
    drive_request(r);
    awaited_results.push_back(advance_bus(r));
  endtask

  // Keeps ticking until the running operation has finished on the bus.
  task automatic finish_operation();
    while (run_op != OP_TICK) send_tick(random_request());
  endtask

  // The register is written only with no request outstanding and the bus idle.
  task automatic set_quarter_bit(input logic [15:0] v);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    qbt_model = v;
    speeds_used++;
  endtask

  // Result side: each result is compared with the oldest prediction, then the
  // receiver draws how long it stalls before taking the next one.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result scl %b sda %b busy %b done %b data %0h", $time,
                 scl_level, sda_level, busy_res, done_res, read_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("scl_level", want.scl, scl_level);
        compare_field("sda_level", want.sda, sda_level);
        compare_field("busy_res", want.busy, busy_res);
        compare_field("done_res", want.done, done_res);
        compare_field("read_data", want.data, read_data);
      end
      stall_left = idle_draw(recv_calm);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    plan_row_t plan[$];
    res_t      got;
    tick_req_t r;

    // Idle ticks with the field extremes, then the unused codes, which must
    // leave both lines released.
    plan.push_back(plan_row(OP_TICK, 11'h000, 8'h00, 1'b0, NO_CFG, NO_DRAIN, 1'b1, IDLE_RES));
    plan.push_back(plan_row(OP_TICK, 11'h7FF, 8'hFF, 1'b1, NO_CFG, NO_DRAIN, 1'b1, IDLE_RES));
    plan.push_back(plan_row(OP_SPARE5, 11'h555, 8'hAA, 1'b0, NO_CFG, NO_DRAIN, 1'b1, IDLE_RES));
    plan.push_back(plan_row(OP_SPARE6, 11'h2AA, 8'h55, 1'b1, NO_CFG, NO_DRAIN, 1'b1, IDLE_RES));
    plan.push_back(plan_row(OP_SPARE7, 11'h7FF, 8'hFF, 1'b1, NO_CFG, NO_DRAIN, 1'b1, IDLE_RES));
    // Bus reset at the reset bus speed, with commands arriving while it runs.
    plan.push_back(plan_row(OP_BUS_RESET, 11'h000, 8'h00, 1'b1, NO_CFG, NO_DRAIN, 1'b1,
                            START_RES));
    plan.push_back(plan_row(OP_WRITE, 11'h7FF, 8'hFF, 1'b0, NO_CFG, NO_DRAIN, 1'b0, IDLE_RES));
    plan.push_back(plan_row(OP_SPARE7, 11'h000, 8'h00, 1'b1, NO_CFG, DRAIN, 1'b0, IDLE_RES));
    // Zero quarter-bit setting, and a write whose first acknowledge is very late.
    plan.push_back(plan_row(OP_WRITE, 11'h7FF, 8'hFF, 1'b1, 0, DRAIN_LATE_ACK, 1'b1,
                            START_RES));
    plan.push_back(plan_row(OP_READ, 11'h7FF, 8'h00, 1'b0, NO_CFG, DRAIN, 1'b0, IDLE_RES));
    plan.push_back(plan_row(OP_INVERT, 11'h000, 8'h00, 1'b1, NO_CFG, DRAIN, 1'b0, IDLE_RES));
    plan.push_back(plan_row(OP_WRITE, 11'h000, 8'h00, 1'b0, 1, DRAIN, 1'b0, IDLE_RES));
    plan.push_back(plan_row(OP_READ, 11'h000, 8'hFF, 1'b1, NO_CFG, DRAIN, 1'b0, IDLE_RES));
    plan.push_back(plan_row(OP_INVERT, 11'h7FF, 8'h55, 1'b0, NO_CFG, DRAIN, 1'b0, IDLE_RES));
    plan.push_back(plan_row(OP_BUS_RESET, 11'h2AA, 8'hAA, 1'b0, NO_CFG, DRAIN, 1'b0,
                            IDLE_RES));
    plan.push_back(plan_row(OP_TICK, 11'h155, 8'h00, 1'b1, NO_CFG, NO_DRAIN, 1'b0, IDLE_RES));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_q != NO_CFG) set_quarter_bit(16'(plan[i].set_q));
      drive_request(plan[i].req);
      got = advance_bus(plan[i].req);
      awaited_results.push_back(plan[i].known ? plan[i].want : got);
      if (plan[i].drain == DRAIN_LATE_ACK) ack_hold_left = 60;
      if (plan[i].drain != NO_DRAIN) finish_operation();
    end

    // Random phases, each at its own bus speed and with its own idling mood;
    // every phase ends with the bus idle, and the next speed is written only
    // once all results are in.
    do begin
      set_quarter_bit(($urandom_range(0, 7) == 0) ? 16'd5 : 16'($urandom_range(1, 3)));
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(40, 120)) send_tick(random_request());
      finish_operation();
    end while (ticks_sent < 1700);

    // The widest setting: a bus reset is started and left holding its first
    // slot for the rest of the run.
    set_quarter_bit(16'hFFFF);
    send_calm = 1'b0;
    recv_calm = 1'b0;
    r = random_request();
    r.op = OP_BUS_RESET;
    send_tick(r);
    repeat (60) send_tick(random_request());

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d bus ticks and %0d checked results at %0d quarter-bit settings.",
             ticks_sent, results_seen, speeds_used);
    $display("Completed: %0d writes, %0d reads, %0d expander inverts, %0d bus resets.",
             finished[OP_WRITE], finished[OP_READ], finished[OP_INVERT],
             finished[OP_BUS_RESET]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: i2c_eeprom_byte_master.f
design/i2cm_pkg.sv
design/i2cm_seq.sv
design/i2cm_out_buf.sv
design/i2c_eeprom_byte_master.sv
bench/tb_i2c_eeprom_byte_master.sv
